FILE: hdl/tst_pkg.sv
// shared types and constants for the timer slot table
// no dependencies; imported by every module of the block
`default_nettype none

package tst_pkg;

  // table geometry
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int TIME_W  = 48;
  localparam int TAG_W   = 32;
  localparam int DELAY_W = 24;
  localparam int MS_W    = 10;
  localparam int PROD_W  = DELAY_W + MS_W;
  localparam int SLOTF_W = 6;

  localparam logic [MS_W-1:0]     US_PER_MS = MS_W'(1000);
  localparam logic [TIME_W-1:0]   TIME_MAX  = '1;
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0]   FIRST_SLOT = SLOT_W'(1);

  typedef enum logic [1:0] {
    CMD_SCHED = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_DEL   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_FULL      = 3'd1,
    ST_FIRED     = 3'd2,
    ST_NONE_DUE  = 3'd3,
    ST_DELETED   = 3'd4,
    ST_ALREADY   = 3'd5,
    ST_BAD_ID    = 3'd6
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [TIME_W-1:0]   now_us;
    logic [DELAY_W-1:0]  delay_ms;
    logic [TAG_W-1:0]    tag;
    logic signed [7:0]   slot_id;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOTF_W-1:0]  slot;
    logic [TAG_W-1:0]    fired_tag;
    logic                last;
    logic                next_valid;
    logic [TIME_W-1:0]   next_deadline_us;
  } rsp_t;

  // one slot as read back from the store
  typedef struct packed {
    logic                vld;
    logic [TIME_W-1:0]   deadline;
    logic [TAG_W-1:0]    tag;
  } slot_rd_t;

  // decision of the compare unit for one slot
  typedef struct packed {
    logic take;
    logic due;
    logic free;
  } verdict_t;

endpackage

`default_nettype wire

FILE: hdl/tst_store.sv
// slot storage: deadline and tag memories plus per-slot valid flops
// depends on tst_pkg
`default_nettype none

module tst_store (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           rd_en,
  input  wire [tst_pkg::SLOT_W-1:0]     rd_addr,
  output tst_pkg::slot_rd_t             rd,
  input  wire                           wr_en,
  input  wire [tst_pkg::SLOT_W-1:0]     wr_addr,
  input  wire [tst_pkg::TIME_W-1:0]     wr_deadline,
  input  wire [tst_pkg::TAG_W-1:0]      wr_tag,
  input  wire                           clr_en,
  input  wire [tst_pkg::SLOT_W-1:0]     clr_addr
);
  import tst_pkg::*;

  logic [TIME_W-1:0]     deadline_mem [SLOT_COUNT];
  logic [TAG_W-1:0]      tag_mem      [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;

  // valid flops, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem[wr_addr] <= wr_deadline;
      tag_mem[wr_addr]      <= wr_tag;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.vld      <= valid[rd_addr];
      rd.deadline <= deadline_mem[rd_addr];
      rd.tag      <= tag_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tst_judge.sv
// shared compare unit: due test and running-minimum compare for one slot
// depends on tst_pkg
`default_nettype none

module tst_judge (
  input  tst_pkg::cmd_t                 cmd,
  input  wire [tst_pkg::TIME_W-1:0]     now,
  input  wire                           del_hit,
  input  wire [tst_pkg::SLOT_W-1:0]     del_idx,
  input  wire [tst_pkg::SLOT_W-1:0]     idx,
  input  tst_pkg::slot_rd_t             rd,
  input  wire                           fin,
  input  wire                           sched_ok,
  input  wire [tst_pkg::TIME_W-1:0]     dl_new,
  input  wire                           best_found,
  input  wire [tst_pkg::TIME_W-1:0]     best,
  output tst_pkg::verdict_t             verdict
);
  import tst_pkg::*;

  logic [TIME_W-1:0] cand;
  logic              lt;
  logic              due;
  logic              contrib;

  // the one minimum comparator, shared by the scan and the final merge
  assign cand = fin ? dl_new : rd.deadline;
  assign lt   = cand < best;

  // a slot is due when its deadline is at or before now
  assign due = !fin && rd.vld && (cmd == CMD_RUN) && !(now < rd.deadline);

  // slots that stay pending after the command
  always_comb begin
    if (fin) begin
      contrib = sched_ok;
    end else begin
      contrib = rd.vld && !due && !((cmd == CMD_DEL) && del_hit && (idx == del_idx));
    end
  end

  assign verdict.take = contrib && (!best_found || lt);
  assign verdict.due  = due;
  assign verdict.free = !fin && !rd.vld;

endmodule

`default_nettype wire

FILE: hdl/timer_slot_table.sv
// timer slot table top level: command sequencer and result register
// depends on tst_pkg, tst_store, tst_judge
//
//   channel | signals                     | direction | transfer when
//   req     | req_valid, req_stall, req   | in        | req_valid && !req_stall
//   rsp     | rsp_valid, rsp_stall, rsp   | out       | rsp_valid && !rsp_stall
//
// every command but NOP scans slots 1..SLOT_COUNT-1 through one memory read port.
// a run that fires adds a seek pass over the slots and loads one result per fired slot.
// req_stall is high from acceptance until the last result is loaded.
// rst is synchronous and clears all slots; no clearing pass is needed.
// a stalled result holds in the output register; the sequencer waits for it.
`default_nettype none

module timer_slot_table (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  tst_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output tst_pkg::rsp_t  rsp
);
  import tst_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CALC  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_SEEK  = 8'b0100_0000,
    S_LOAD  = 8'b1000_0000
  } state_t;

  state_t                state;
  cmd_t                  cmd_r;
  logic [TIME_W-1:0]     now_r;
  logic [TAG_W-1:0]      tag_r;
  logic [PROD_W-1:0]     prod;
  logic [TIME_W-1:0]     dl;
  logic                  id_neg;
  logic                  id_bad;
  logic                  del_hit;
  logic [SLOT_W-1:0]     del_idx;
  logic [SLOT_W-1:0]     scan_addr;
  logic                  p_stage;
  logic [SLOT_W-1:0]     p_idx;
  logic                  best_found;
  logic [TIME_W-1:0]     best;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_COUNT-1:0] due_bits;
  logic [SLOT_W-1:0]     fire_left;
  logic [SLOT_W-1:0]     fire_idx;
  status_t               one_status;
  logic [SLOT_W-1:0]     one_slot;

  logic                  out_free;
  logic                  rsp_load;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  slot_rd_t              rd;
  logic                  wr_en;
  logic                  clr_en;
  logic [SLOT_W-1:0]     clr_addr;
  logic                  fin;
  logic                  sched_ok;
  verdict_t              verdict;
  logic [TIME_W:0]       sum;
  logic [7:0]            raw_id;
  logic                  in_range;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = ((state == S_EMIT) || (state == S_LOAD)) && out_free;

  // delete id decode
  assign raw_id   = req.slot_id;
  assign in_range = !raw_id[7] && (raw_id < 8'(SLOT_COUNT));

  // deadline add with saturation
  assign sum = {1'b0, now_r} + (TIME_W + 1)'(prod);

  // store port control
  assign fin      = (state == S_FIN);
  assign sched_ok = (cmd_r == CMD_SCHED) && free_found;
  assign rd_en    = (state == S_SCAN) || ((state == S_SEEK) && due_bits[fire_idx]);
  assign rd_addr  = (state == S_SCAN) ? scan_addr : fire_idx;
  assign wr_en    = fin && sched_ok;
  assign clr_en   = (fin && del_hit) || ((state == S_LOAD) && out_free);
  assign clr_addr = fin ? del_idx : fire_idx;

  tst_store u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd          (rd),
    .wr_en       (wr_en),
    .wr_addr     (free_idx),
    .wr_deadline (dl),
    .wr_tag      (tag_r),
    .clr_en      (clr_en),
    .clr_addr    (clr_addr)
  );

  tst_judge u_judge (
    .cmd        (cmd_r),
    .now        (now_r),
    .del_hit    (del_hit),
    .del_idx    (del_idx),
    .idx        (p_idx),
    .rd         (rd),
    .fin        (fin),
    .sched_ok   (sched_ok),
    .dl_new     (dl),
    .best_found (best_found),
    .best       (best),
    .verdict    (verdict)
  );

  // result valid flag: set on load, cleared once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_r      <= req.cmd;
            now_r      <= req.now_us;
            tag_r      <= req.tag;
            prod       <= PROD_W'(req.delay_ms) * PROD_W'(US_PER_MS);
            id_neg     <= raw_id[7];
            id_bad     <= !raw_id[7] && !in_range;
            del_hit    <= (req.cmd == CMD_DEL) && in_range;
            del_idx    <= raw_id[SLOT_W-1:0];
            scan_addr  <= FIRST_SLOT;
            p_stage    <= 1'b0;
            best_found <= 1'b0;
            free_found <= 1'b0;
            due_bits   <= '0;
            fire_left  <= '0;
            state      <= (req.cmd == CMD_NOP) ? S_IDLE : S_CALC;
          end
        end

        S_CALC: begin
          dl    <= sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          state <= S_SCAN;
        end

        S_SCAN, S_DRAIN: begin
          // slot read last cycle is judged now
          if (p_stage) begin
            if (verdict.take) begin
              best       <= rd.deadline;
              best_found <= 1'b1;
            end
            if (verdict.due) begin
              due_bits[p_idx] <= 1'b1;
              fire_left       <= fire_left + 1'b1;
            end
            if (verdict.free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= p_idx;
            end
          end
          if (state == S_SCAN) begin
            p_stage <= 1'b1;
            p_idx   <= scan_addr;
            if (scan_addr == LAST_SLOT) begin
              state <= S_DRAIN;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end else begin
            p_stage <= 1'b0;
            state   <= S_FIN;
          end
        end

        S_FIN: begin
          // merge the new deadline and pick the single result
          if (verdict.take) begin
            best       <= dl;
            best_found <= 1'b1;
          end
          one_slot <= '0;
          case (cmd_r)
            CMD_SCHED: begin
              one_status <= free_found ? ST_SCHEDULED : ST_FULL;
              one_slot   <= free_found ? free_idx : '0;
            end
            CMD_RUN: begin
              one_status <= ST_NONE_DUE;
            end
            default: begin
              if (id_neg) begin
                one_status <= ST_ALREADY;
              end else if (id_bad) begin
                one_status <= ST_BAD_ID;
              end else begin
                one_status <= ST_DELETED;
                one_slot   <= del_idx;
              end
            end
          endcase
          fire_idx <= FIRST_SLOT;
          if ((cmd_r == CMD_RUN) && (fire_left != '0)) begin
            state <= S_SEEK;
          end else begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            rsp.status           <= one_status;
            rsp.slot             <= SLOTF_W'(one_slot);
            rsp.fired_tag        <= '0;
            rsp.last             <= 1'b1;
            rsp.next_valid       <= best_found;
            rsp.next_deadline_us <= best_found ? best : '0;
            state                <= S_IDLE;
          end
        end

        S_SEEK: begin
          if (due_bits[fire_idx]) begin
            state <= S_LOAD;
          end else begin
            fire_idx <= fire_idx + 1'b1;
          end
        end

        S_LOAD: begin
          if (out_free) begin
            rsp.status           <= ST_FIRED;
            rsp.slot             <= SLOTF_W'(fire_idx);
            rsp.fired_tag        <= rd.tag;
            rsp.last             <= (fire_left == SLOT_W'(1));
            rsp.next_valid       <= best_found;
            rsp.next_deadline_us <= best_found ? best : '0;
            due_bits[fire_idx]   <= 1'b0;
            fire_left            <= fire_left - 1'b1;
            fire_idx             <= fire_idx + 1'b1;
            state                <= (fire_left == SLOT_W'(1)) ? S_IDLE : S_SEEK;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a fired result always names a real slot
  a_fired_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FIRED) |-> rsp.slot != '0)
    else $error("fired result with slot zero");

  // the fire pass only loads while transfers remain
  a_fire_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> fire_left != '0)
    else $error("fire pass with no due slots left");

  // no pending slot means a zero deadline on the result
  a_next_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.next_valid |-> rsp.next_deadline_us == '0)
    else $error("deadline reported with nothing pending");

  // seek only hands over to the load step
  a_seek_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEEK) |=> (state == S_SEEK) || (state == S_LOAD))
    else $error("seek left without loading");

endmodule

`default_nettype wire
